// ----- rtl/cll_pkg.sv -----
// ----------------------------------------------------------------------------
// Cursor linked list engine package
// Operation and status codes, store control group, shared limits.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int VALUE_W     = 32;
  localparam int CELL_OUT_W  = 4;

  typedef enum logic [1:0] {
    OP_INS_FIRST = 2'd0,
    OP_INS_LAST  = 2'd1,
    OP_DELETE    = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic rd_en;
    logic lk_we;
    logic el_we;
  } mem_ctl_t;

endpackage

// ----- rtl/cll_store.sv -----
// ----------------------------------------------------------------------------
// Cursor linked list cell store
// Element and link memories, one shared read address, registered read data.
// ----------------------------------------------------------------------------
module cll_store #(
  parameter int POOL_SIZE = 16,
  parameter int IW        = $clog2(POOL_SIZE),
  parameter int LW        = IW + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cll_pkg::mem_ctl_t              ctl,
  input  logic [IW-1:0]                  rd_addr,
  input  logic [IW-1:0]                  lk_addr,
  input  logic [LW-1:0]                  lk_data,
  input  logic [IW-1:0]                  el_addr,
  input  logic [cll_pkg::VALUE_W-1:0]    el_data,
  output logic [LW-1:0]                  rd_link,
  output logic [cll_pkg::VALUE_W-1:0]    rd_elem
);

  logic [LW-1:0]               lk_mem [POOL_SIZE];
  logic [cll_pkg::VALUE_W-1:0] el_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0]        lk_vld;
  logic [LW-1:0]               rst_link;

  always_comb begin
    if (rd_addr == IW'(POOL_SIZE - 1)) begin
      rst_link = LW'(POOL_SIZE);
    end else begin
      rst_link = LW'(rd_addr) + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_vld <= '0;
    end else if (ctl.lk_we) begin
      lk_vld[lk_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lk_we) begin
      lk_mem[lk_addr] <= lk_data;
    end
    if (ctl.el_we) begin
      el_mem[el_addr] <= el_data;
    end
    if (ctl.rd_en) begin
      rd_link <= lk_vld[rd_addr] ? lk_mem[rd_addr] : rst_link;
      rd_elem <= el_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/cll_seq.sv -----
// ----------------------------------------------------------------------------
// Cursor linked list sequencer
// Walks the list one cell per cycle unless the output stalls, updates heads and links, holds results.
// ----------------------------------------------------------------------------
module cll_seq #(
  parameter int POOL_SIZE = 16,
  parameter int IW        = $clog2(POOL_SIZE),
  parameter int LW        = IW + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  cll_pkg::op_t                     s_func,
  input  logic [cll_pkg::VALUE_W-1:0]      s_value,
  output logic                             m_valid,
  input  logic                             m_ready,
  output cll_pkg::status_t                 m_status,
  output logic [cll_pkg::VALUE_W-1:0]      m_element,
  output logic [cll_pkg::CELL_OUT_W-1:0]   m_cell,
  output logic                             m_last,
  output cll_pkg::mem_ctl_t                ctl,
  output logic [IW-1:0]                    rd_addr,
  output logic [IW-1:0]                    lk_addr,
  output logic [LW-1:0]                    lk_data,
  output logic [IW-1:0]                    el_addr,
  output logic [cll_pkg::VALUE_W-1:0]      el_data,
  input  logic [LW-1:0]                    rd_link,
  input  logic [cll_pkg::VALUE_W-1:0]      rd_elem
);

  localparam logic [LW-1:0] NONE = LW'(POOL_SIZE);

  typedef enum logic [6:0] {
    IDLE  = 7'b0000001,
    TAKE  = 7'b0000010,
    TWALK = 7'b0000100,
    DWALK = 7'b0001000,
    DFREE = 7'b0010000,
    RWALK = 7'b0100000,
    RESP  = 7'b1000000
  } state_t;

  function automatic logic is_cell(input logic [LW-1:0] c);
    return c < LW'(POOL_SIZE);
  endfunction

  state_t                       state, state_next;
  cll_pkg::op_t                 func_q, func_next;
  logic [cll_pkg::VALUE_W-1:0]  val_q, val_next;
  logic [LW-1:0]                cell_q, cell_next;
  logic [LW-1:0]                cur, cur_next;
  logic [LW-1:0]                prev, prev_next;
  logic [cll_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [LW-1:0]                list_head, list_head_next;
  logic [LW-1:0]                free_head, free_head_next;
  cll_pkg::status_t             res_status, res_status_next;
  logic [IW-1:0]                res_cell, res_cell_next;
  logic                         out_free;
  logic                         out_load;
  cll_pkg::status_t             out_status;
  logic [cll_pkg::VALUE_W-1:0]  out_elem;
  logic [IW-1:0]                out_cell;
  logic                         out_last;
  logic                         rd_last;

  assign s_ready  = (state == IDLE);
  assign out_free = !m_valid || m_ready;
  assign rd_last  = !is_cell(rd_link) || (cnt == cll_pkg::CNT_W'(cll_pkg::MAX_RESULTS - 1));
  assign el_addr  = cell_q[IW-1:0];
  assign el_data  = val_q;

  always_comb begin
    state_next      = state;
    func_next       = func_q;
    val_next        = val_q;
    cell_next       = cell_q;
    cur_next        = cur;
    prev_next       = prev;
    cnt_next        = cnt;
    list_head_next  = list_head;
    free_head_next  = free_head;
    res_status_next = res_status;
    res_cell_next   = res_cell;
    ctl             = '0;
    rd_addr         = cur[IW-1:0];
    lk_addr         = cur[IW-1:0];
    lk_data         = NONE;
    out_load        = 1'b0;
    out_status      = cll_pkg::ST_OK;
    out_elem        = '0;
    out_cell        = '0;
    out_last        = 1'b1;

    unique case (state)
      IDLE: begin
        if (s_valid) begin
          func_next = s_func;
          val_next  = s_value;
          unique case (s_func) inside
            cll_pkg::OP_INS_FIRST, cll_pkg::OP_INS_LAST: begin
              if (!is_cell(free_head)) begin
                res_status_next = cll_pkg::ST_FULL;
                res_cell_next   = '0;
                state_next      = RESP;
              end else begin
                cell_next  = free_head;
                ctl.rd_en  = 1'b1;
                rd_addr    = free_head[IW-1:0];
                state_next = TAKE;
              end
            end
            cll_pkg::OP_DELETE: begin
              if (!is_cell(list_head)) begin
                res_status_next = cll_pkg::ST_NOT_FOUND;
                res_cell_next   = '0;
                state_next      = RESP;
              end else begin
                cur_next   = list_head;
                prev_next  = NONE;
                ctl.rd_en  = 1'b1;
                rd_addr    = list_head[IW-1:0];
                state_next = DWALK;
              end
            end
            default: begin
              if (!is_cell(list_head)) begin
                res_status_next = cll_pkg::ST_EMPTY;
                res_cell_next   = '0;
                state_next      = RESP;
              end else begin
                cur_next   = list_head;
                cnt_next   = '0;
                ctl.rd_en  = 1'b1;
                rd_addr    = list_head[IW-1:0];
                state_next = RWALK;
              end
            end
          endcase
        end
      end
      TAKE: begin
        free_head_next  = rd_link;
        ctl.el_we       = 1'b1;
        ctl.lk_we       = 1'b1;
        lk_addr         = cell_q[IW-1:0];
        res_status_next = cll_pkg::ST_OK;
        res_cell_next   = cell_q[IW-1:0];
        if (func_q == cll_pkg::OP_INS_FIRST) begin
          lk_data        = list_head;
          list_head_next = cell_q;
          state_next     = RESP;
        end else if (!is_cell(list_head)) begin
          list_head_next = cell_q;
          state_next     = RESP;
        end else begin
          cur_next   = list_head;
          ctl.rd_en  = 1'b1;
          rd_addr    = list_head[IW-1:0];
          state_next = TWALK;
        end
      end
      TWALK: begin
        if (is_cell(rd_link)) begin
          cur_next  = rd_link;
          ctl.rd_en = 1'b1;
          rd_addr   = rd_link[IW-1:0];
        end else begin
          ctl.lk_we  = 1'b1;
          lk_data    = cell_q;
          state_next = RESP;
        end
      end
      DWALK: begin
        if (rd_elem == val_q) begin
          if (!is_cell(prev)) begin
            list_head_next = rd_link;
          end else begin
            ctl.lk_we = 1'b1;
            lk_addr   = prev[IW-1:0];
            lk_data   = rd_link;
          end
          state_next = DFREE;
        end else if (is_cell(rd_link)) begin
          prev_next = cur;
          cur_next  = rd_link;
          ctl.rd_en = 1'b1;
          rd_addr   = rd_link[IW-1:0];
        end else begin
          res_status_next = cll_pkg::ST_NOT_FOUND;
          res_cell_next   = '0;
          state_next      = RESP;
        end
      end
      DFREE: begin
        ctl.lk_we       = 1'b1;
        lk_data         = free_head;
        free_head_next  = cur;
        res_status_next = cll_pkg::ST_OK;
        res_cell_next   = cur[IW-1:0];
        state_next      = RESP;
      end
      RWALK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = cll_pkg::ST_OK;
          out_elem   = rd_elem;
          out_cell   = cur[IW-1:0];
          out_last   = rd_last;
          if (rd_last) begin
            state_next = IDLE;
          end else begin
            cur_next  = rd_link;
            cnt_next  = cnt + cll_pkg::CNT_W'(1);
            ctl.rd_en = 1'b1;
            rd_addr   = rd_link[IW-1:0];
          end
        end
      end
      RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = res_status;
          out_cell   = res_cell;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      list_head <= NONE;
      free_head <= '0;
      m_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_q     <= func_next;
    val_q      <= val_next;
    cell_q     <= cell_next;
    cur        <= cur_next;
    prev       <= prev_next;
    cnt        <= cnt_next;
    res_status <= res_status_next;
    res_cell   <= res_cell_next;
    if (out_load) begin
      m_status  <= out_status;
      m_element <= out_elem;
      m_cell    <= cll_pkg::CELL_OUT_W'(out_cell);
      m_last    <= out_last;
    end
  end

endmodule

// ----- rtl/cursor_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// Cursor linked list engine
// One singly linked list of 32-bit values in a pool of cells with a
// free list. Input beats carry an operation in s_tuser and a value in
// s_tdata: insert first, insert last, delete value, read list.
// Each insert or delete gives one result beat; a read gives one beat per
// element from the head (at most 16), the final one with m_tlast, or a
// single empty-status beat. Failures give status full or not found.
// Insert first goes from TAKE straight to RESP; insert last walks to the
// tail and delete walks to the match first. A read streams elements from
// the head, one element per cycle while the receiver keeps up. The walk
// reads one cell per cycle from the link and element memories.
// s_tready is high only while the sequencer is idle; one item at a time.
// Reset empties the list and chains free cells 0 to POOL_SIZE-1 in order,
// at once, with no clearing pass. A stalled receiver holds the result in
// the output register and the sequencer waits before the next beat.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine #(
  parameter int POOL_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] element, [35:32] cell_index, [39:36] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = IW + 1;

  cll_pkg::mem_ctl_t                    ctl;
  logic [IW-1:0]                        rd_addr;
  logic [IW-1:0]                        lk_addr;
  logic [LW-1:0]                        lk_data;
  logic [IW-1:0]                        el_addr;
  logic [cll_pkg::VALUE_W-1:0]          el_data;
  logic [LW-1:0]                        rd_link;
  logic [cll_pkg::VALUE_W-1:0]          rd_elem;
  cll_pkg::status_t                     status;
  logic [cll_pkg::VALUE_W-1:0]          element;
  logic [cll_pkg::CELL_OUT_W-1:0]       cell_index;

  cll_seq #(
    .POOL_SIZE (POOL_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_func    (cll_pkg::op_t'(s_tuser)),
    .s_value   (s_tdata),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_status  (status),
    .m_element (element),
    .m_cell    (cell_index),
    .m_last    (m_tlast),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .lk_addr   (lk_addr),
    .lk_data   (lk_data),
    .el_addr   (el_addr),
    .el_data   (el_data),
    .rd_link   (rd_link),
    .rd_elem   (rd_elem)
  );

  cll_store #(
    .POOL_SIZE (POOL_SIZE)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .lk_addr (lk_addr),
    .lk_data (lk_data),
    .el_addr (el_addr),
    .el_data (el_data),
    .rd_link (rd_link),
    .rd_elem (rd_elem)
  );

  assign m_tdata = {4'b0000, cell_index, element};
  assign m_tuser = status;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("engine ready right after accepting a beat");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != cll_pkg::ST_OK) |-> m_tlast)
    else $error("failure status without last");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ctl.lk_we && ctl.rd_en |-> lk_addr != rd_addr)
    else $error("link write and read hit the same cell");

endmodule
